>>> rtl/core/assert_macros.svh
// Assertion macros shared by the pixel fetch/decode RTL.
// Needs clk and rst_n (active low) names passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/bpfd_pkg.sv
// Types, codes and helper functions of the bitmap pixel fetch/decode block.
// No dependencies; imported by bpfd_cfg, bpfd_front, bpfd_back and the top level.
package bpfd_pkg;

  localparam int InDataW  = 72;
  localparam int OutDataW = 64;
  localparam int AddrW    = 35;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    CmdLocate   = 2'd0,
    CmdDecode   = 2'd1,
    CmdPalWrite = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    RegColorDepth   = 3'd0,
    RegImageWidth   = 3'd1,
    RegImageHeight  = 3'd2,
    RegRedMask      = 3'd3,
    RegGreenMask    = 3'd4,
    RegBlueMask     = 3'd5,
    RegPaletteEn    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    KindAddr  = 1'b0,
    KindColor = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    OpLocate   = 3'd0,
    OpDecMask  = 3'd1,
    OpDecPal   = 3'd2,
    OpDecZero  = 3'd3,
    OpPalWrite = 3'd4
  } op_t;

  typedef struct packed {
    logic [5:0]  depth;
    logic [15:0] width;
    logic [16:0] height;
    logic        pal_en;
  } cfg_front_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  rsh;
    logic [2:0]  lsh;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
  } cfg_back_t;

  typedef struct packed {
    op_t         op;
    logic [19:0] stride;
    logic [17:0] row;
    logic [18:0] xoff;
    logic [31:0] word;
    logic [7:0]  idx;
  } q_entry_t;

  // Shift setup for one channel: s = trailing zeros, n = run of ones at s
  // (capped at 8). Right shift by s+n-8 when that is positive, else left.
  function automatic chan_cfg_t chan_setup(input logic [31:0] mask);
    logic [5:0]  s;
    logic [5:0]  n;
    logic [31:0] sm;
    logic [5:0]  gap;
    chan_cfg_t   c;
    s = 6'd0;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) begin
        s = 6'(i);
      end
    end
    sm = mask >> s[4:0];
    n = 6'd8;
    for (int i = 7; i >= 0; i--) begin
      if (!sm[i]) begin
        n = 6'(i);
      end
    end
    gap = 6'd8 - n;
    c.mask = mask;
    c.rsh  = 5'd0;
    c.lsh  = 3'd0;
    if (n >= 6'd8) begin
      c.rsh = s[4:0];
    end else if (s >= gap) begin
      c.rsh = 5'(s - gap);
    end else begin
      c.lsh = 3'(gap - s);
    end
    return c;
  endfunction

  function automatic logic [7:0] chan_conv(input logic [31:0] raw, input chan_cfg_t c);
    logic [31:0] t;
    logic [7:0]  u;
    t = (raw & c.mask) >> c.rsh;
    u = t[7:0] << c.lsh;
    return u;
  endfunction

endpackage

>>> rtl/core/bpfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bpfd_cfg.sv
// Configuration register file; derives per-channel shift setup on write.
// Depends on bpfd_pkg.
module bpfd_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  output bpfd_pkg::cfg_front_t front_cfg,
  output bpfd_pkg::cfg_back_t  back_cfg
);
  import bpfd_pkg::*;

  cfg_front_t front_r, front_nxt;
  cfg_back_t  back_r, back_nxt;
  chan_cfg_t  setup;

  assign setup = chan_setup(cfg_wdata);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    if (cfg_wen) begin
      case (cfg_index)
        RegColorDepth:  front_nxt.depth  = cfg_wdata[5:0];
        RegImageWidth:  front_nxt.width  = cfg_wdata[15:0];
        RegImageHeight: front_nxt.height = cfg_wdata[16:0];
        RegRedMask:     back_nxt.red     = setup;
        RegGreenMask:   back_nxt.green   = setup;
        RegBlueMask:    back_nxt.blue    = setup;
        RegPaletteEn:   front_nxt.pal_en = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.depth  <= 6'd24;
      front_r.width  <= 16'd1;
      front_r.height <= 17'd1;
      front_r.pal_en <= 1'b0;
      back_r.red     <= chan_setup(32'h00ff_0000);
      back_r.green   <= chan_setup(32'h0000_ff00);
      back_r.blue    <= chan_setup(32'h0000_00ff);
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  assign front_cfg = front_r;
  assign back_cfg  = back_r;

endmodule

>>> rtl/core/bpfd_front.sv
// Front end: accepts input beats, classifies the command, prepares locate
// terms and the extracted pixel value, and pushes work into the queue.
// Depends on bpfd_pkg.
module bpfd_front #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COORD_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  input  bpfd_pkg::cfg_front_t cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output bpfd_pkg::q_entry_t   q_din
);
  import bpfd_pkg::*;

  localparam logic [15:0] CoordMask = 16'((32'd1 << COORD_BITS) - 1);

  logic        f_valid_r, f_valid_nxt;
  q_entry_t    f_entry_r, f_entry_nxt;
  q_entry_t    entry;
  logic        keep;
  logic        take;
  logic [15:0] x_c, y_c;
  logic [31:0] raw;
  logic [7:0]  pidx;
  logic [21:0] wprod, xprod;
  logic [22:0] wsum;
  logic        h_pos;
  logic        d_small, d_ok;
  logic [6:0]  pos_full;
  logic [3:0]  sh;
  logic [8:0]  low_mask;
  logic [31:0] val;

  assign x_c  = in_tdata[15:0] & CoordMask;
  assign y_c  = in_tdata[31:16] & CoordMask;
  assign raw  = in_tdata[63:32];
  assign pidx = in_tdata[71:64];

  assign q_push    = f_valid_r && !q_full;
  assign in_tready = !f_valid_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign q_din     = f_entry_r;

  // Locate terms: row stride in bytes, signed row index, byte offset of x.
  assign wprod = 22'(cfg.width) * 22'(cfg.depth);
  assign wsum  = 23'(wprod) + 23'd31;
  assign xprod = 22'(x_c) * 22'(cfg.depth);
  assign h_pos = !cfg.height[16] && (cfg.height != 17'd0);

  // Pixel extraction from the raw little-endian word.
  assign d_small  = (cfg.depth == 6'd1) || (cfg.depth == 6'd2) ||
                    (cfg.depth == 6'd4) || (cfg.depth == 6'd8);
  assign d_ok     = d_small || (cfg.depth == 6'd16) || (cfg.depth == 6'd24) ||
                    (cfg.depth == 6'd32);
  assign pos_full = 7'(x_c[2:0]) * 7'(cfg.depth[3:0]);
  assign sh       = 4'd8 - cfg.depth[3:0] - {1'b0, pos_full[2:0]};
  assign low_mask = (9'd1 << cfg.depth[3:0]) - 9'd1;

  always_comb begin
    if (d_small) begin
      val = 32'((raw[7:0] >> sh) & low_mask[7:0]);
    end else if (cfg.depth == 6'd16) begin
      val = {16'd0, raw[15:0]};
    end else if (cfg.depth == 6'd24) begin
      val = {8'd0, raw[23:0]};
    end else if (cfg.depth == 6'd32) begin
      val = raw;
    end else begin
      val = 32'd0;
    end
  end

  always_comb begin
    entry.op     = OpDecZero;
    entry.stride = {wsum[22:5], 2'b00};
    entry.row    = h_pos ? (18'(cfg.height) - 18'(y_c) - 18'd1) : 18'(y_c);
    entry.xoff   = xprod[21:3];
    entry.word   = val;
    entry.idx    = val[7:0];
    keep         = 1'b0;
    case (in_tuser)
      CmdLocate: begin
        entry.op = OpLocate;
        keep     = 1'b1;
      end
      CmdDecode: begin
        keep = 1'b1;
        if (!d_ok) begin
          entry.op = OpDecZero;
        end else if (cfg.pal_en) begin
          entry.op = (val < 32'(PALETTE_DEPTH)) ? OpDecPal : OpDecZero;
        end else begin
          entry.op = OpDecMask;
        end
      end
      CmdPalWrite: begin
        entry.op   = OpPalWrite;
        entry.word = raw;
        entry.idx  = pidx;
        keep       = (9'(pidx) < 9'(PALETTE_DEPTH));
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_entry_nxt = f_entry_r;
    if (take) begin
      f_valid_nxt = keep;
      f_entry_nxt = entry;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_entry_r <= f_entry_nxt;
  end

endmodule

>>> rtl/core/bpfd_fifo.sv
// Small register queue between front and back ends; head read in place.
// No dependencies.
module bpfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/core/bpfd_back.sv
// Back end: executes queued work (address multiply, mask conversion,
// palette read/write) into the output register. Depends on bpfd_pkg, bpfd_ram.
module bpfd_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpfd_pkg::cfg_back_t cfg,
  input  logic                q_empty,
  input  bpfd_pkg::q_entry_t  q_dout,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,   // byte_address[34:0], color_rgb[58:35]
  output logic                out_tuser    // kind
);
  import bpfd_pkg::*;

  localparam int IdxW = $clog2(PALETTE_DEPTH);

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [AddrW-1:0]   addr_r, addr_nxt;
  logic [23:0]        color_r, color_nxt;
  logic               pal_sel_r, pal_sel_nxt;
  logic               adv;
  logic [23:0]        rgb;
  logic signed [38:0] prod;
  logic [AddrW-1:0]   loc_addr;
  logic               ram_we, ram_re;
  logic [23:0]        pal_rdata;

  assign adv   = !out_valid_r || out_tready;
  assign q_pop = !q_empty && adv;

  assign rgb = {chan_conv(q_dout.word, cfg.red), chan_conv(q_dout.word, cfg.green),
                chan_conv(q_dout.word, cfg.blue)};

  assign prod     = $signed({1'b0, q_dout.stride}) * $signed(q_dout.row);
  assign loc_addr = prod[AddrW-1:0] + AddrW'(q_dout.xoff);

  assign ram_we = q_pop && (q_dout.op == OpPalWrite);
  assign ram_re = q_pop && (q_dout.op == OpDecPal);

  bpfd_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_dout.idx[IdxW-1:0]),
    .wdata(rgb),
    .re   (ram_re),
    .raddr(q_dout.idx[IdxW-1:0]),
    .rdata(pal_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    color_nxt     = color_r;
    pal_sel_nxt   = pal_sel_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KindColor;
      addr_nxt      = '0;
      color_nxt     = 24'd0;
      pal_sel_nxt   = 1'b0;
      case (q_dout.op)
        OpLocate: begin
          kind_nxt = KindAddr;
          addr_nxt = loc_addr;
        end
        OpDecMask:  color_nxt = rgb;
        OpDecPal:   pal_sel_nxt = 1'b1;
        OpDecZero:  color_nxt = 24'd0;
        OpPalWrite: out_valid_nxt = 1'b0;
        default:    out_valid_nxt = 1'b0;
      endcase
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    addr_r    <= addr_nxt;
    color_r   <= color_nxt;
    pal_sel_r <= pal_sel_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {5'd0, (pal_sel_r ? pal_rdata : color_r), addr_r};

endmodule

>>> rtl/core/bmp_pixel_fetch_decode.sv
// Bitmap (DIB) pixel locate/decode unit, top level.
// Depends on bpfd_pkg, bpfd_cfg, bpfd_front, bpfd_fifo, bpfd_back, bpfd_ram.
//
// Input beats arrive on in_*: tuser carries the command (locate, decode,
// palette write), tdata the column, row, raw pixel word and palette index.
// Locate and decode each give one beat on out_*: tuser is the kind (byte
// address or color), tdata holds the byte address and the 24-bit RGB value.
// Palette writes and the unused command give no output beat.
// The user must write registers on cfg_* while the block is idle (the block
// itself does not enforce this); a write takes effect for the next accepted beat.
// Throughput: one beat per clock while out_tready is high. With an empty queue
// an accepted beat passes through the front register, the four-entry queue and
// the back end's output register (palette reads come from the palette RAM's
// registered port).
// When out_tready is low the output register holds; the queue keeps taking
// beats until it fills, then in_tready drops.
// Reset loads the register defaults and empties the pipeline. Palette RAM
// contents are undefined after reset and are never cleared.
`include "assert_macros.svh"

module bmp_pixel_fetch_decode #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COORD_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // x[15:0], y[31:16], raw_word[63:32], palette_index[71:64]
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // byte_address[34:0], color_rgb[58:35], zero fill
  output logic        out_tuser,  // kind
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import bpfd_pkg::*;

  cfg_front_t front_cfg;
  cfg_back_t  back_cfg;
  q_entry_t   q_din, q_dout;
  logic       q_push, q_pop, q_full, q_empty;

  bpfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .front_cfg(front_cfg),
    .back_cfg (back_cfg)
  );

  bpfd_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (front_cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  bpfd_fifo #(
    .WIDTH($bits(q_entry_t)),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .full (q_full),
    .empty(q_empty)
  );

  bpfd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (back_cfg),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `ASSERT_NEVER(a_no_push_full, clk, rst_n, q_push && q_full, "queue push while full")
  `ASSERT_AT(a_push_fills, clk, rst_n, q_push |=> !q_empty, "queue empty after push")
  `ASSERT_AT(a_ready_room, clk, rst_n, !q_full |-> in_tready, "input stalled with queue room")

endmodule
